@@ sv/tmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Trimmed mean filter package
// Shared sizes, the sequencer state type and the structs that pass between
// the accumulator, the divider and the top level.
// ----------------------------------------------------------------------------
package tmf_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_SAMPLES = 1024;

   // The sum must hold MAX_SAMPLES full-scale samples without wrapping.
   localparam longint unsigned MAX_SUM = longint'(MAX_SAMPLES) * ((longint'(1) << SAMPLE_W) - 1);
   localparam int SUM_W  = $clog2(MAX_SUM + 1);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_WRITE
   } tmf_state_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] largest;
      logic [SAMPLE_W-1:0] smallest;
      logic [CNT_W-1:0]    count;
      logic                exceeded;
   } acc_stats_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ sv/tmf_accum.sv @@
// ----------------------------------------------------------------------------
// Trimmed mean filter accumulator
// Keeps the running sum, maximum, minimum and count of the current burst and
// shows the statistics that include the sample now being offered.
// ----------------------------------------------------------------------------
module tmf_accum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           last,
   input  logic [tmf_pkg::SAMPLE_W-1:0]   sample,
   output tmf_pkg::acc_stats_type         stats_next
);
   import tmf_pkg::*;

   acc_stats_type stats_ff;
   acc_stats_type stats_in;
   acc_stats_type stats_reset;

   always_comb begin
      stats_reset          = '0;
      stats_reset.smallest = '1;

      stats_next = stats_ff;
      if (stats_ff.count >= CNT_W'(MAX_SAMPLES)) begin
         // Samples past the bound are dropped and only flagged.
         stats_next.exceeded = 1'b1;
      end else begin
         stats_next.sum   = stats_ff.sum + SUM_W'(sample);
         stats_next.count = stats_ff.count + CNT_W'(1);
         if (sample > stats_ff.largest) begin
            stats_next.largest = sample;
         end
         if (sample < stats_ff.smallest) begin
            stats_next.smallest = sample;
         end
      end

      stats_in = stats_ff;
      if (accept) begin
         stats_in = last ? stats_reset : stats_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= stats_reset;
      end else begin
         stats_ff <= stats_in;
      end
   end

endmodule

@@ sv/tmf_divider.sv @@
// ----------------------------------------------------------------------------
// Trimmed mean filter divider
// Restoring divider: one shared subtract and compare per cycle, one quotient
// bit per cycle, SUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module tmf_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmf_pkg::SUM_W-1:0]     dividend,
   input  logic [tmf_pkg::CNT_W-1:0]     divisor,
   output tmf_pkg::div_status_type       status,
   output logic [tmf_pkg::SAMPLE_W-1:0]  quotient
);
   import tmf_pkg::*;

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // No borrow means the shifted remainder holds the divisor.
         if (!diff[CNT_W]) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   // The trimmed sum never exceeds divisor times full scale, so the quotient
   // fits in a sample.
   assign quotient    = quo_ff[SAMPLE_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ sv/trimmed_mean_filter_unit.sv @@
// The transaction carrying the last sample starts the bit-serial divider, and the
// result becomes valid once the divider is done and the result register is free.
// Throughput: one sample per cycle within a burst; after the last sample the
// input stalls while the divider runs, and longer while the previous result
// transaction is still waiting. Reset: synchronous, active high; clears the
// burst statistics, the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
// Trimmed mean filter unit
// Accumulates a burst of samples and returns the mean without its largest
// and smallest sample, using one shared iterative divider.
// ----------------------------------------------------------------------------
module trimmed_mean_filter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tmf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tmf_pkg::SAMPLE_W-1:0]  rsp_average,
   output logic                          rsp_overflow
);
   import tmf_pkg::*;

   tmf_state_type         state_ff, state_in;
   acc_stats_type         stats_next;
   div_status_type        div_status;
   logic [SAMPLE_W-1:0]   quotient;
   logic                  req_accept;
   logic                  div_start;
   logic [SUM_W-1:0]      trimmed;
   logic [CNT_W-1:0]      divisor;
   logic                  zero_ff, zero_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_average_ff, rsp_average_in;
   logic                  rsp_overflow_ff, rsp_overflow_in;

   assign req_ready  = (state_ff == ST_ACCUM);
   assign req_accept = req_valid && req_ready;
   assign div_start  = req_accept && req_last;

   assign trimmed = stats_next.sum - SUM_W'(stats_next.largest) - SUM_W'(stats_next.smallest);
   assign divisor = stats_next.count - CNT_W'(2);

   tmf_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .last       (req_last),
      .sample     (req_sample),
      .stats_next (stats_next)
   );

   tmf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (trimmed),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   always_comb begin
      state_in        = state_ff;
      zero_in         = zero_ff;
      ovf_in          = ovf_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_average_in  = rsp_average_ff;
      rsp_overflow_in = rsp_overflow_ff;

      unique case (state_ff)
         ST_ACCUM: begin
            if (div_start) begin
               // Short or overlong bursts still run the divider; the result
               // is forced to zero at the end.
               zero_in  = stats_next.exceeded || (stats_next.count <= CNT_W'(2));
               ovf_in   = stats_next.exceeded;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_average_in  = zero_ff ? '0 : quotient;
               rsp_overflow_in = ovf_ff;
               state_in        = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zero_ff         <= zero_in;
      ovf_ff          <= ovf_in;
      rsp_average_ff  <= rsp_average_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_average  = rsp_average_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

@@ sv/tmf_checker.sv @@
// ----------------------------------------------------------------------------
// Trimmed mean filter checker
// Port-level assertions on the filter unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module tmf_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tmf_pkg::SAMPLE_W-1:0]  rsp_average,
   input  logic                          rsp_overflow
);
   import tmf_pkg::*;

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // An overflowed burst always reports a zero average.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_average == '0)
      else $error("overflow result with nonzero average");

   // The input stalls once the last sample of a burst is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input accepted while dividing");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind trimmed_mean_filter_unit tmf_checker u_tmf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_last     (req_last),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_average  (rsp_average),
   .rsp_overflow (rsp_overflow)
);
